// ===== rtl/gcm_pkg.sv =====
package gcm_pkg;

   // Widths of the money values and of the slot number.
   localparam int AMOUNT_W   = 24;
   localparam int SLOT_COUNT = 8;
   localparam int SLOT_W     = 3;

   // Number of denomination slots that take part in a request (1 to 8).
   localparam int NUM_DENOMS = 8;

   // A slot count outside 1 to 8 is clamped into that range.
   localparam int ACTIVE_SLOTS = (NUM_DENOMS < 1) ? 1 :
                                 (NUM_DENOMS > SLOT_COUNT) ? SLOT_COUNT : NUM_DENOMS;

   // The divider retires one quotient bit per cycle.
   localparam int DIV_STEPS  = AMOUNT_W;
   localparam int STEP_W     = $clog2(DIV_STEPS);

   localparam logic [SLOT_W-1:0] TOP_SLOT   = SLOT_W'(ACTIVE_SLOTS - 1);
   localparam logic [SLOT_W-1:0] FIRST_SLOT = '0;
   localparam logic [STEP_W-1:0] LAST_STEP  = '0;
   localparam logic [STEP_W-1:0] FIRST_STEP = STEP_W'(DIV_STEPS - 1);

   // Value of each denomination register after reset.
   localparam logic [AMOUNT_W-1:0] DENOM_0_RESET = AMOUNT_W'(1);
   localparam logic [AMOUNT_W-1:0] DENOM_N_RESET = '0;

   // Controller states.
   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_START = 4'b0010,
      ST_DIV   = 4'b0100,
      ST_PUSH  = 4'b1000
   } gcm_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic              load_amount;
      logic              start_slot;
      logic              div_step;
      logic              push;
      logic [SLOT_W-1:0] slot;
   } gcm_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic denom_zero;
      logic rsp_free;
   } gcm_stat_type;

endpackage

// ===== rtl/gcm_datapath.sv =====
module gcm_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [gcm_pkg::SLOT_W-1:0]     csr_index,
   input  logic [gcm_pkg::AMOUNT_W-1:0]   csr_data,
   input  logic [gcm_pkg::AMOUNT_W-1:0]   req_amount,
   input  gcm_pkg::gcm_cmd_type           cmd,
   output gcm_pkg::gcm_stat_type          stat,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [gcm_pkg::SLOT_W-1:0]     rsp_slot_index,
   output logic [gcm_pkg::AMOUNT_W-1:0]   rsp_note_count,
   output logic [gcm_pkg::AMOUNT_W-1:0]   rsp_leftover,
   output logic                           rsp_last
);
   import gcm_pkg::*;

   logic [AMOUNT_W-1:0] denom_ff [SLOT_COUNT];
   logic [AMOUNT_W-1:0] divisor;
   logic [AMOUNT_W-1:0] remain_ff, remain_in;
   logic [AMOUNT_W-1:0] quot_ff, quot_in;
   logic [AMOUNT_W-1:0] part_ff, part_in;
   logic [AMOUNT_W:0]   shifted;
   logic [AMOUNT_W:0]   diff;
   logic                out_valid_ff, out_valid_in;
   logic [SLOT_W-1:0]   out_slot_ff;
   logic [AMOUNT_W-1:0] out_count_ff;
   logic [AMOUNT_W-1:0] out_left_ff;
   logic                out_last_ff;

   // Denomination registers, written from the configuration port.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            denom_ff[i] <= (i == 0) ? DENOM_0_RESET : DENOM_N_RESET;
         end
      end else if (csr_we) begin
         denom_ff[csr_index] <= csr_data;
      end
   end

   assign divisor         = denom_ff[cmd.slot];
   assign stat.denom_zero = (divisor == '0);
   assign stat.rsp_free   = !out_valid_ff || rsp_ready;

   // One restoring division step: shift in the next dividend bit, subtract if it fits.
   assign shifted = {part_ff, quot_ff[AMOUNT_W-1]};
   assign diff    = shifted - {1'b0, divisor};

   always_comb begin
      remain_in = remain_ff;
      quot_in   = quot_ff;
      part_in   = part_ff;
      if (cmd.load_amount) begin
         remain_in = req_amount;
      end
      if (cmd.start_slot) begin
         // An unused slot pays nothing and keeps the remainder as it is.
         if (stat.denom_zero) begin
            quot_in = '0;
            part_in = remain_ff;
         end else begin
            quot_in = remain_ff;
            part_in = '0;
         end
      end
      if (cmd.div_step) begin
         if (!diff[AMOUNT_W]) begin
            part_in = diff[AMOUNT_W-1:0];
            quot_in = {quot_ff[AMOUNT_W-2:0], 1'b1};
         end else begin
            part_in = shifted[AMOUNT_W-1:0];
            quot_in = {quot_ff[AMOUNT_W-2:0], 1'b0};
         end
      end
      if (cmd.push) begin
         remain_in = part_ff;
      end
   end

   always_ff @(posedge clock) begin
      remain_ff <= remain_in;
      quot_ff   <= quot_in;
      part_ff   <= part_in;
   end

   // Output register: holds a result beat until the receiver takes it.
   assign out_valid_in = cmd.push ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         out_slot_ff  <= cmd.slot;
         out_count_ff <= quot_ff;
         out_last_ff  <= (cmd.slot == FIRST_SLOT);
         out_left_ff  <= (cmd.slot == FIRST_SLOT) ? part_ff : '0;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_slot_index = out_slot_ff;
   assign rsp_note_count = out_count_ff;
   assign rsp_leftover   = out_left_ff;
   assign rsp_last       = out_last_ff;

endmodule

// ===== rtl/gcm_ctrl.sv =====
module gcm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  gcm_pkg::gcm_stat_type stat,
   output gcm_pkg::gcm_cmd_type  cmd
);
   import gcm_pkg::*;

   gcm_state_type     state_ff, state_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [STEP_W-1:0] step_ff, step_in;

   // Sequencer: for each slot, set up, divide bit by bit (an unused slot skips this), then hand off the beat.
   always_comb begin
      state_in        = state_ff;
      slot_in         = slot_ff;
      step_in         = step_ff;
      req_ready       = 1'b0;
      cmd.load_amount = 1'b0;
      cmd.start_slot  = 1'b0;
      cmd.div_step    = 1'b0;
      cmd.push        = 1'b0;
      cmd.slot        = slot_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_amount = 1'b1;
               slot_in         = TOP_SLOT;
               state_in        = ST_START;
            end
         end
         ST_START: begin
            cmd.start_slot = 1'b1;
            step_in        = FIRST_STEP;
            state_in       = stat.denom_zero ? ST_PUSH : ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff - 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (stat.rsp_free) begin
               cmd.push = 1'b1;
               if (slot_ff == FIRST_SLOT) begin
                  state_in = ST_IDLE;
               end else begin
                  slot_in  = slot_ff - 1'b1;
                  state_in = ST_START;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         slot_ff  <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         slot_ff  <= slot_in;
         step_ff  <= step_in;
      end
   end

endmodule

// ===== rtl/greedy_change_maker.sv =====
// Greedy change maker.
// A request beat on req_ carries an amount. The block splits it over the
// programmed denominations, from the highest slot down to slot 0, and sends
// one rsp_ beat per slot: the slot number, the count of units paid from that
// slot, and on the slot 0 beat (rsp_last high) the amount left unpaid.
// The user must write denominations on the csr_ port only while no request
// is in flight; the block itself does not enforce this. A zero marks an
// unused slot, which reports a count of 0. Each slot goes through a setup
// step, the shared one-bit-per-cycle restoring divider, and a step that
// loads the output register; an unused slot skips the divider. A new
// request is taken once the slot 0 beat has been loaded into the output
// register.
// When the receiver stalls, the finished beat waits in the output register
// and the sequencer holds before loading the next one.
// Reset empties the output register, returns the sequencer to idle, sets
// denom_0 to 1 and the other denominations to 0.
module greedy_change_maker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [gcm_pkg::SLOT_W-1:0]   csr_index,
   input  logic [gcm_pkg::AMOUNT_W-1:0] csr_data,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [gcm_pkg::AMOUNT_W-1:0] req_amount,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [gcm_pkg::SLOT_W-1:0]   rsp_slot_index,
   output logic [gcm_pkg::AMOUNT_W-1:0] rsp_note_count,
   output logic [gcm_pkg::AMOUNT_W-1:0] rsp_leftover,
   output logic                         rsp_last
);
   import gcm_pkg::*;

   gcm_cmd_type  cmd;
   gcm_stat_type stat;

   // Sequencer.
   gcm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Registers, divider and output stage.
   gcm_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_amount     (req_amount),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_slot_index (rsp_slot_index),
      .rsp_note_count (rsp_note_count),
      .rsp_leftover   (rsp_leftover),
      .rsp_last       (rsp_last)
   );

endmodule

// ===== sim/gcm_payout_checker.sv =====
`timescale 1ns / 100ps

// Watches the register, request and response ports of the change maker.
// It keeps its own copy of the denominations and splits every accepted
// amount greedily. Each response beat is compared with the oldest predicted
// beat, one field at a time.
module gcm_payout_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [gcm_pkg::SLOT_W-1:0]   csr_index,
   input  logic [gcm_pkg::AMOUNT_W-1:0] csr_data,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic [gcm_pkg::AMOUNT_W-1:0] req_amount,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic [gcm_pkg::SLOT_W-1:0]   rsp_slot_index,
   input  logic [gcm_pkg::AMOUNT_W-1:0] rsp_note_count,
   input  logic [gcm_pkg::AMOUNT_W-1:0] rsp_leftover,
   input  logic                         rsp_last,
   output int                           fail_count,
   output int                           pending_beats
);
   import gcm_pkg::*;

   // The block clamps its slot count into 1..SLOT_COUNT.
   localparam int USED_SLOTS = (NUM_DENOMS < 1) ? 1 :
                               (NUM_DENOMS > SLOT_COUNT) ? SLOT_COUNT : NUM_DENOMS;

   typedef struct packed {
      logic [SLOT_W-1:0]   slot_index;
      logic [AMOUNT_W-1:0] note_count;
      logic [AMOUNT_W-1:0] leftover;
      logic                last;
   } payout_beat_type;

   logic [AMOUNT_W-1:0] denom_value [SLOT_COUNT];
   payout_beat_type     expected_payouts [$];

   // Split one amount from the highest slot down. An unused slot pays
   // nothing and leaves the remainder alone; only slot 0 reports what is left.
   function automatic void queue_payout(input logic [AMOUNT_W-1:0] amount);
      logic [AMOUNT_W-1:0] remain;
      logic [AMOUNT_W-1:0] units;
      payout_beat_type     beat;
      int                  s;
      remain = amount;
      for (s = USED_SLOTS - 1; s >= 0; s--) begin
         units = '0;
         if (denom_value[s] != '0) begin
            units  = remain / denom_value[s];
            remain = remain - units * denom_value[s];
         end
         beat.slot_index = SLOT_W'(s);
         beat.note_count = units;
         beat.leftover   = (s == 0) ? remain : '0;
         beat.last       = (s == 0);
         expected_payouts.push_back(beat);
      end
   endfunction

   function automatic void check_field(input string field, input logic [AMOUNT_W-1:0] want,
                                       input logic [AMOUNT_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", field, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin : track
      payout_beat_type want;
      int              i;
      if (reset) begin
         for (i = 0; i < SLOT_COUNT; i++)
            denom_value[i] = DENOM_N_RESET;
         denom_value[0] = DENOM_0_RESET;
         expected_payouts.delete();
         fail_count = 0;
      end else begin
         // Register writes only come while no request is in flight.
         if (csr_we && int'(csr_index) < SLOT_COUNT)
            denom_value[csr_index] = csr_data;

         // A response beat is matched against the oldest prediction.
         if (rsp_valid && rsp_ready) begin
            if (expected_payouts.size() == 0) begin
               $error("payout beat with nothing expected: slot %0d count %0d",
                      rsp_slot_index, rsp_note_count);
               fail_count++;
            end else begin
               want = expected_payouts.pop_front();
               check_field("slot_index", AMOUNT_W'(want.slot_index), AMOUNT_W'(rsp_slot_index));
               check_field("note_count", want.note_count, rsp_note_count);
               check_field("leftover", want.leftover, rsp_leftover);
               check_field("last", AMOUNT_W'(want.last), AMOUNT_W'(rsp_last));
            end
         end

         if (req_valid && req_ready)
            queue_payout(req_amount);
      end
      pending_beats = expected_payouts.size();
   end

endmodule

// ===== sim/greedy_change_maker_tb.sv =====
`timescale 1ns / 100ps

// Drives withdrawal requests and denomination writes into the change maker,
// paces both channels, and gives the verdict from the checker's count.
module greedy_change_maker_tb;
   import gcm_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_CYCLES    = 600;
   localparam int SETTLE_CYCLES  = 4;
   localparam int DRAIN_CYCLES   = 40;
   localparam int ITEMS_PER_SET  = 30;
   localparam int RANDOM_SETS    = 8;

   // Ways of filling the denomination table for a random set.
   localparam int STYLE_LADDER = 0;
   localparam int STYLE_SPARSE = 1;
   localparam int STYLE_WILD   = 2;

   localparam logic [AMOUNT_W-1:0] MAX_AMOUNT = '1;

   logic                clock;
   logic                reset;
   logic                csr_we;
   logic [SLOT_W-1:0]   csr_index;
   logic [AMOUNT_W-1:0] csr_data;
   logic                req_valid;
   logic                req_ready;
   logic [AMOUNT_W-1:0] req_amount;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [SLOT_W-1:0]   rsp_slot_index;
   logic [AMOUNT_W-1:0] rsp_note_count;
   logic [AMOUNT_W-1:0] rsp_leftover;
   logic                rsp_last;

   int   fail_count;
   int   pending_beats;
   int   req_idle_pct;
   int   rsp_idle_pct;
   logic hold_rsp;

   greedy_change_maker dut (.*);

   gcm_payout_checker checker_inst (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Offer one amount after a random gap and hold it until it is taken.
   task automatic send_amount(input logic [AMOUNT_W-1:0] amount);
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_amount <= amount;
      do @(posedge clock); while (!req_ready);
   endtask

   // Stop offering and wait until every predicted beat has arrived.
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending_beats == 0);
   endtask

   // Write all eight denominations once the block has gone idle.
   task automatic program_denoms(input logic [AMOUNT_W-1:0] values [SLOT_COUNT]);
      int s;
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      for (s = 0; s < SLOT_COUNT; s++) begin
         @(negedge clock);
         csr_we    <= 1'b1;
         csr_index <= SLOT_W'(s);
         csr_data  <= values[s];
         @(negedge clock);
         csr_we <= 1'b0;
      end
   endtask

   task automatic program_random_denoms(input int style);
      logic [AMOUNT_W-1:0] values [SLOT_COUNT];
      logic [AMOUNT_W-1:0] step;
      int                  s;
      step = AMOUNT_W'($urandom_range(1, 3));
      for (s = 0; s < SLOT_COUNT; s++) begin
         case (style)
            STYLE_LADDER: begin
               values[s] = step;
            end
            STYLE_SPARSE: begin
               values[s] = ($urandom_range(2) == 0) ? '0 : step;
            end
            STYLE_WILD: begin
               // Unsorted full-width values with the odd unused slot.
               values[s] = ($urandom_range(5) == 0) ? '0 : AMOUNT_W'($urandom());
            end
            default: begin
               values[s] = step;
            end
         endcase
         step = step * AMOUNT_W'($urandom_range(2, 5));
      end
      program_denoms(values);
   endtask

   // Mostly small and mid-size amounts, with full-width ones mixed in.
   function automatic logic [AMOUNT_W-1:0] pick_amount();
      case ($urandom_range(4))
         0: pick_amount = AMOUNT_W'($urandom());
         1: pick_amount = AMOUNT_W'($urandom_range(0, 2000));
         2: pick_amount = AMOUNT_W'($urandom_range(0, 1 << 20));
         3: pick_amount = AMOUNT_W'($urandom_range(0, 99));
         default: pick_amount = ($urandom_range(1) == 0) ? MAX_AMOUNT : '0;
      endcase
   endfunction

   // Receiver: random stalls, plus one long hold-off when asked.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
         end
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Watchdog: ends the run when nothing moves for too long.
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we)
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Stimulus and verdict.
   initial begin
      int set_no;
      int item_no;
      reset        = 1'b1;
      csr_we       = 1'b0;
      csr_index    = '0;
      csr_data     = '0;
      req_valid    = 1'b0;
      req_amount   = '0;
      hold_rsp     = 1'b0;
      req_idle_pct = 12;
      rsp_idle_pct = 68;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // After reset only slot 0 is in use, in units of one.
      send_amount('0);
      send_amount(MAX_AMOUNT);
      send_amount(24'd1);

      // Ordinary ascending ladder.
      program_denoms('{1, 2, 5, 10, 20, 50, 100, 500});
      send_amount('0);
      send_amount(24'd1);
      send_amount(24'd388);
      send_amount(24'd888);
      send_amount(24'd499);
      send_amount(24'd500);
      send_amount(MAX_AMOUNT);

      // Unused slots, slot 0 among them, so a leftover remains.
      program_denoms('{0, 3, 0, 25, 0, 0, 1000, 0});
      send_amount(24'd2);
      send_amount(24'd7);
      send_amount(24'd999999);
      send_amount(MAX_AMOUNT);

      // Unsorted table: still paid from the top slot down.
      program_denoms('{9, 1, MAX_AMOUNT, 4, 7, 3, 2, 100});
      send_amount(MAX_AMOUNT);
      send_amount(MAX_AMOUNT - 1'b1);
      send_amount(24'd123456);

      // Every slot at the largest value.
      program_denoms('{MAX_AMOUNT, MAX_AMOUNT, MAX_AMOUNT, MAX_AMOUNT,
                       MAX_AMOUNT, MAX_AMOUNT, MAX_AMOUNT, MAX_AMOUNT});
      send_amount(MAX_AMOUNT);
      send_amount(MAX_AMOUNT - 1'b1);

      // Every slot unused: the whole amount is left over.
      program_denoms('{0, 0, 0, 0, 0, 0, 0, 0});
      send_amount(24'd12345);
      send_amount('0);

      // Random tables and amounts under changing channel pressure.
      for (set_no = 0; set_no < RANDOM_SETS; set_no++) begin
         if (set_no == 3) begin
            req_idle_pct = 68;
            rsp_idle_pct = 12;
         end
         if (set_no == 6) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         program_random_denoms(set_no % 3);
         for (item_no = 0; item_no < ITEMS_PER_SET; item_no++) begin
            // Long receiver hold-off while requests keep coming, so the
            // block backs up and stalls its request port.
            if (set_no == 1 && item_no == 4)
               hold_rsp = 1'b1;
            // Pause the sender until the block has fully drained.
            if (item_no == 15)
               drain_results();
            send_amount(pick_amount());
         end
      end

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
